/* src/tld_pkg.sv */
package tld_pkg;

    typedef struct packed {
        logic signed [23:0] first_center_x;
        logic signed [23:0] first_center_y;
        logic signed [23:0] first_center_z;
        logic signed [15:0] first_dir_x;
        logic signed [15:0] first_dir_y;
        logic signed [15:0] first_dir_z;
        logic signed [23:0] second_center_x;
        logic signed [23:0] second_center_y;
        logic signed [23:0] second_center_z;
        logic signed [15:0] second_dir_x;
        logic signed [15:0] second_dir_y;
        logic signed [15:0] second_dir_z;
    } in_item_t;

    typedef struct packed {
        logic [31:0] metric_value;
        logic        saturated;
    } out_item_t;

    localparam int FRONT_STAGES = 6;
    localparam int SQRT_STAGES  = 8;
    localparam int SQRT_STEPS   = 4;
    localparam int DIV_STAGES   = 10;
    localparam int DIV_STEPS    = 4;

    localparam logic [15:0]        SCALE_RESET = 16'd256;
    localparam logic [31:0]        SAT_VALUE   = 32'hFFFF_FFFF;
    localparam logic signed [33:0] ONE_Q28     = 34'sh1000_0000;
    localparam logic [56:0]        ONE_Q56     = 57'h100_0000_0000_0000;

    // One restoring square root lane: radicand shifts out two bits per step.
    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        sqrt_lane_t  dline;
        sqrt_lane_t  ang;
        logic [28:0] absc;
        logic        sat;
    } sq_t;

    // One restoring divider lane: dividend shifts out one bit per step.
    typedef struct packed {
        logic [39:0] num;
        logic [28:0] rem;
        logic [39:0] quo;
        logic [28:0] den;
    } div_lane_t;

    typedef struct packed {
        div_lane_t dline;
        div_lane_t ang;
        logic      sat;
    } dv_t;

    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t lane);
        sqrt_lane_t  res;
        logic [35:0] trial;
        logic [35:0] cand;
        res   = lane;
        trial = {lane.rem, lane.rad[63:62]};
        cand  = {2'b00, lane.root, 2'b01};
        if (trial >= cand) begin
            res.rem  = 34'(trial - cand);
            res.root = {lane.root[30:0], 1'b1};
        end else begin
            res.rem  = trial[33:0];
            res.root = {lane.root[30:0], 1'b0};
        end
        res.rad = {lane.rad[61:0], 2'b00};
        return res;
    endfunction

    function automatic div_lane_t div_step(input div_lane_t lane);
        div_lane_t   res;
        logic [29:0] trial;
        res   = lane;
        trial = {lane.rem, lane.num[39]};
        if (trial >= {1'b0, lane.den}) begin
            res.rem = 29'(trial - {1'b0, lane.den});
            res.quo = {lane.quo[38:0], 1'b1};
        end else begin
            res.rem = trial[28:0];
            res.quo = {lane.quo[38:0], 1'b0};
        end
        res.num = {lane.num[38:0], 1'b0};
        return res;
    endfunction

endpackage

/* src/tld_sqrt_stage.sv */
module tld_sqrt_stage (
    input  logic         clk,
    input  logic         load,
    input  tld_pkg::sq_t data_in,
    output tld_pkg::sq_t data_out
);

    tld_pkg::sq_t data_reg;
    tld_pkg::sq_t data_next;

    // Both square roots advance by the same number of result bits per stage.
    always_comb
    begin
        data_next = data_in;
        for (int i = 0; i < tld_pkg::SQRT_STEPS; i++)
        begin
            data_next.dline = tld_pkg::sqrt_step(data_next.dline);
            data_next.ang   = tld_pkg::sqrt_step(data_next.ang);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule

/* src/tld_div_stage.sv */
module tld_div_stage (
    input  logic         clk,
    input  logic         load,
    input  tld_pkg::dv_t data_in,
    output tld_pkg::dv_t data_out
);

    tld_pkg::dv_t data_reg;
    tld_pkg::dv_t data_next;

    // Both quotients advance by the same number of bits per stage.
    always_comb
    begin
        data_next = data_in;
        for (int i = 0; i < tld_pkg::DIV_STEPS; i++)
        begin
            data_next.dline = tld_pkg::div_step(data_next.dline);
            data_next.ang   = tld_pkg::div_step(data_next.ang);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule

/* src/triplet_line_distance_metric_top.sv */
// Line-pair distance metric. Each input beat carries two line segments (center
// in Q15.8, unit direction in Q1.14); each output beat carries the larger
// perpendicular center-to-line distance divided by distance_scale, plus the
// absolute tangent of the angle between the directions, in unsigned Q24.8
// with a saturation flag. The block accepts one beat per cycle while in_stall
// is low; each beat passes through the 24 pipeline stages (six arithmetic
// stages, eight square root stages of four root bits each, ten divider
// stages of four quotient bits each) and then the output register. Every
// stage holds its beat until the next stage frees up, so bubbles close up
// and input is taken while a result waits at the output.
// The saturated flag is raised, and metric_value is all ones, when the sum
// overflows 32 bits, when the directions are perpendicular, or when
// distance_scale is zero. distance_scale resets to 1.0 and should only be
// written while no beats are in flight; the write port is always ready.
module triplet_line_distance_metric_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tld_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tld_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    localparam int SQ_BASE = tld_pkg::FRONT_STAGES;
    localparam int DV_BASE = SQ_BASE + tld_pkg::SQRT_STAGES;
    localparam int NS      = DV_BASE + tld_pkg::DIV_STAGES;

    // Configuration register.
    logic [15:0] scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= tld_pkg::SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_reg <= cfg_data;
        end
    end

    // Stage control. A stage may load when it is empty or when the stage
    // after it loads in the same cycle.
    logic              valid_reg [NS];
    logic              out_valid_reg;
    logic [NS:0]       en;

    always_comb
    begin
        en[NS] = !out_valid_reg || !out_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k + 1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
            if (en[NS])
            begin
                out_valid_reg <= valid_reg[NS - 1];
            end
        end
    end

    // Unpack the input beat into per-axis vectors.
    logic signed [23:0] c1 [3];
    logic signed [23:0] c2 [3];
    logic signed [15:0] d1 [3];
    logic signed [15:0] d2 [3];

    assign c1[0] = in_data.first_center_x;
    assign c1[1] = in_data.first_center_y;
    assign c1[2] = in_data.first_center_z;
    assign c2[0] = in_data.second_center_x;
    assign c2[1] = in_data.second_center_y;
    assign c2[2] = in_data.second_center_z;
    assign d1[0] = in_data.first_dir_x;
    assign d1[1] = in_data.first_dir_y;
    assign d1[2] = in_data.first_dir_z;
    assign d2[0] = in_data.second_dir_x;
    assign d2[1] = in_data.second_dir_y;
    assign d2[2] = in_data.second_dir_z;

    // Stage A: center difference and direction component products.
    logic signed [24:0] a_v_reg   [3];
    logic signed [15:0] a_d1_reg  [3];
    logic signed [15:0] a_d2_reg  [3];
    logic signed [31:0] a_dd_reg  [3];
    logic signed [24:0] a_v_next  [3];
    logic signed [31:0] a_dd_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_v_next[i]  = 25'(c2[i]) - 25'(c1[i]);
            a_dd_next[i] = d1[i] * d2[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_v_reg[i]  <= a_v_next[i];
                a_d1_reg[i] <= d1[i];
                a_d2_reg[i] <= d2[i];
                a_dd_reg[i] <= a_dd_next[i];
            end
        end
    end

    // Stage B: projections onto each line and the clamped direction cosine.
    // The second line sees the negated difference, so its projection is
    // negated as a whole.
    logic signed [42:0] b_ta_reg;
    logic signed [42:0] b_tb_reg;
    logic signed [24:0] b_v_reg  [3];
    logic signed [15:0] b_d1_reg [3];
    logic signed [15:0] b_d2_reg [3];
    logic [28:0]        b_absc_reg;
    logic               b_sat_reg;
    logic signed [42:0] b_ta_next;
    logic signed [42:0] b_tb_next;
    logic [28:0]        b_absc_next;
    logic               b_sat_next;

    always_comb
    begin
        logic signed [40:0] pa;
        logic signed [40:0] pb;
        logic signed [42:0] tb_pos;
        logic signed [33:0] csum;
        b_ta_next = '0;
        tb_pos    = '0;
        csum      = '0;
        for (int i = 0; i < 3; i++)
        begin
            pa        = a_d1_reg[i] * a_v_reg[i];
            pb        = a_d2_reg[i] * a_v_reg[i];
            b_ta_next = b_ta_next + 43'(pa);
            tb_pos    = tb_pos + 43'(pb);
            csum      = csum + 34'(a_dd_reg[i]);
        end
        b_tb_next = -tb_pos;
        if (csum > tld_pkg::ONE_Q28)
        begin
            csum = tld_pkg::ONE_Q28;
        end
        else if (csum < -tld_pkg::ONE_Q28)
        begin
            csum = -tld_pkg::ONE_Q28;
        end
        b_absc_next = (csum < 0) ? 29'(-csum) : 29'(csum);
        b_sat_next  = (b_absc_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_ta_reg   <= b_ta_next;
            b_tb_reg   <= b_tb_next;
            b_absc_reg <= b_absc_next;
            b_sat_reg  <= b_sat_next;
            for (int i = 0; i < 3; i++)
            begin
                b_v_reg[i]  <= a_v_reg[i];
                b_d1_reg[i] <= a_d1_reg[i];
                b_d2_reg[i] <= a_d2_reg[i];
            end
        end
    end

    // Stage C: scale each direction by its projection; square the cosine.
    logic signed [58:0] c_pa_reg  [3];
    logic signed [58:0] c_pb_reg  [3];
    logic signed [24:0] c_v_reg   [3];
    logic [56:0]        c_sq_reg;
    logic [28:0]        c_absc_reg;
    logic               c_sat_reg;
    logic signed [58:0] c_pa_next [3];
    logic signed [58:0] c_pb_next [3];
    logic [56:0]        c_sq_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_pa_next[i] = b_ta_reg * b_d1_reg[i];
            c_pb_next[i] = b_tb_reg * b_d2_reg[i];
        end
        c_sq_next = b_absc_reg * b_absc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_pa_reg[i] <= c_pa_next[i];
                c_pb_reg[i] <= c_pb_next[i];
                c_v_reg[i]  <= b_v_reg[i];
            end
            c_sq_reg   <= c_sq_next;
            c_absc_reg <= b_absc_reg;
            c_sat_reg  <= b_sat_reg;
        end
    end

    // Stage D: residual vectors, rounding half up at bit 28; sine squared.
    logic signed [32:0] d_ra_reg  [3];
    logic signed [32:0] d_rb_reg  [3];
    logic [56:0]        d_rad_reg;
    logic [28:0]        d_absc_reg;
    logic               d_sat_reg;
    logic signed [32:0] d_ra_next [3];
    logic signed [32:0] d_rb_next [3];

    always_comb
    begin
        logic signed [59:0] ra_sum;
        logic signed [59:0] rb_sum;
        for (int i = 0; i < 3; i++)
        begin
            ra_sum       = 60'(c_pa_reg[i]) + 60'sh800_0000;
            rb_sum       = 60'(c_pb_reg[i]) + 60'sh800_0000;
            d_ra_next[i] = 33'(c_v_reg[i]) - 33'(ra_sum >>> 28);
            d_rb_next[i] = -33'(c_v_reg[i]) - 33'(rb_sum >>> 28);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_ra_reg[i] <= d_ra_next[i];
                d_rb_reg[i] <= d_rb_next[i];
            end
            d_rad_reg  <= tld_pkg::ONE_Q56 - c_sq_reg;
            d_absc_reg <= c_absc_reg;
            d_sat_reg  <= c_sat_reg;
        end
    end

    // Stage E: squared residual components.
    logic [63:0] e_sa_reg  [3];
    logic [63:0] e_sb_reg  [3];
    logic [56:0] e_rad_reg;
    logic [28:0] e_absc_reg;
    logic        e_sat_reg;
    logic [63:0] e_sa_next [3];
    logic [63:0] e_sb_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_sa_next[i] = d_ra_reg[i] * d_ra_reg[i];
            e_sb_next[i] = d_rb_reg[i] * d_rb_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_sa_reg[i] <= e_sa_next[i];
                e_sb_reg[i] <= e_sb_next[i];
            end
            e_rad_reg  <= d_rad_reg;
            e_absc_reg <= d_absc_reg;
            e_sat_reg  <= d_sat_reg;
        end
    end

    // Stage F: sum of squares, larger of the two lines, square root setup.
    tld_pkg::sq_t f_reg;
    tld_pkg::sq_t f_next;

    always_comb
    begin
        logic [63:0] da;
        logic [63:0] db;
        da = e_sa_reg[0] + e_sa_reg[1] + e_sa_reg[2];
        db = e_sb_reg[0] + e_sb_reg[1] + e_sb_reg[2];
        f_next.dline.rad  = (da > db) ? da : db;
        f_next.dline.rem  = '0;
        f_next.dline.root = '0;
        f_next.ang.rad    = 64'(e_rad_reg);
        f_next.ang.rem    = '0;
        f_next.ang.root   = '0;
        f_next.absc       = e_absc_reg;
        f_next.sat        = e_sat_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            f_reg <= f_next;
        end
    end

    // Square root stages.
    tld_pkg::sq_t sq_bus [tld_pkg::SQRT_STAGES + 1];

    assign sq_bus[0] = f_reg;

    for (genvar k = 0; k < tld_pkg::SQRT_STAGES; k++)
    begin : g_sqrt
        tld_sqrt_stage u_stage (
            .clk      (clk),
            .load     (en[SQ_BASE + k]),
            .data_in  (sq_bus[k]),
            .data_out (sq_bus[k + 1])
        );
    end

    // Divider setup: distance over the scale register, sine over |cosine|.
    // Both dividends carry eight extra fraction bits for the Q.8 result.
    tld_pkg::dv_t dv_bus [tld_pkg::DIV_STAGES + 1];
    tld_pkg::dv_t dv_first;
    tld_pkg::sq_t sq_last;

    assign sq_last = sq_bus[tld_pkg::SQRT_STAGES];

    always_comb
    begin
        dv_first.dline.num = {sq_last.dline.root, 8'h00};
        dv_first.dline.rem = '0;
        dv_first.dline.quo = '0;
        dv_first.dline.den = 29'(scale_reg);
        dv_first.ang.num   = {sq_last.ang.root, 8'h00};
        dv_first.ang.rem   = '0;
        dv_first.ang.quo   = '0;
        dv_first.ang.den   = sq_last.absc;
        dv_first.sat       = sq_last.sat || (scale_reg == '0);
    end

    assign dv_bus[0] = dv_first;

    for (genvar k = 0; k < tld_pkg::DIV_STAGES; k++)
    begin : g_div
        tld_div_stage u_stage (
            .clk      (clk),
            .load     (en[DV_BASE + k]),
            .data_in  (dv_bus[k]),
            .data_out (dv_bus[k + 1])
        );
    end

    // Output register: add the two terms and saturate.
    tld_pkg::out_item_t out_data_reg;
    tld_pkg::out_item_t out_data_next;

    always_comb
    begin
        logic [40:0] total;
        logic        sat;
        total = 41'(dv_bus[tld_pkg::DIV_STAGES].dline.quo)
              + 41'(dv_bus[tld_pkg::DIV_STAGES].ang.quo);
        sat   = dv_bus[tld_pkg::DIV_STAGES].sat || (total[40:32] != '0);
        out_data_next.saturated    = sat;
        out_data_next.metric_value = sat ? tld_pkg::SAT_VALUE : total[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[NS])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    // A saturated result always carries the clipped value.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.saturated || out_data.metric_value == tld_pkg::SAT_VALUE))
        else $error("saturated result without clipped value");

    // Input is held off only when the whole pipeline is full and blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && valid_reg[0] && valid_reg[NS - 1]))
        else $error("input stalled with room in the pipeline");

    // An accepted beat occupies the first stage on the next cycle.
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted beat lost at pipeline entry");
`endif

endmodule

/* tb/sv/tb_triplet_line_distance_metric_top.sv */
module tb_triplet_line_distance_metric_top;

    localparam int LATENCY = 25;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    tld_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    tld_pkg::out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [15:0] cfg_data;

    triplet_line_distance_metric_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // Predictor state: the one register, kept in step with every write.
    logic [15:0] scale_shadow;

    // Beats waiting to be driven, and metric results still owed by the block.
    tld_pkg::in_item_t pending_beats[$];
    tld_pkg::out_item_t owed_metrics[$];

    int errors;
    int metrics_seen;
    int sat_seen;
    longint cycle_count;

    // When set, the driver holds off so the pipeline can drain completely.
    logic drain_hold;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Squared distance, Q.16, from point p to the line through c along d.
    function automatic longint unsigned perp_dist_sq(input longint c[3], input longint d[3],
                                                     input longint p[3]);
        longint v[3];
        longint t;
        longint r;
        longint prod;
        longint q;
        longint unsigned sum;
        t = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = p[i] - c[i];
            t += d[i] * v[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            prod = t * d[i];
            // Round half up: arithmetic shift of x + 2^27 floors correctly.
            q = (prod + (64'sd1 <<< 27)) >>> 28;
            r = v[i] - q;
            sum += longint'(r * r);
        end
        return sum;
    endfunction

    function automatic tld_pkg::out_item_t predict_metric(input tld_pkg::in_item_t b,
                                                          input logic [15:0] scale);
        longint c1[3], d1[3], c2[3], d2[3];
        longint unsigned da, db, dmax, dlen, dterm, aterm, total, absc, s;
        longint c;
        logic sat;
        tld_pkg::out_item_t res;
        c1[0] = b.first_center_x; c1[1] = b.first_center_y; c1[2] = b.first_center_z;
        d1[0] = b.first_dir_x; d1[1] = b.first_dir_y; d1[2] = b.first_dir_z;
        c2[0] = b.second_center_x; c2[1] = b.second_center_y; c2[2] = b.second_center_z;
        d2[0] = b.second_dir_x; d2[1] = b.second_dir_y; d2[2] = b.second_dir_z;
        sat = 1'b0;
        da = perp_dist_sq(c1, d1, c2);
        db = perp_dist_sq(c2, d2, c1);
        dmax = (da > db) ? da : db;
        dlen = int_sqrt(dmax);
        if (scale == 0)
        begin
            sat = 1'b1;
            dterm = 0;
        end
        else
            dterm = (dlen << 8) / scale;
        c = d1[0] * d2[0] + d1[1] * d2[1] + d1[2] * d2[2];
        if (c > (64'sd1 <<< 28))
            c = 64'sd1 <<< 28;
        if (c < -(64'sd1 <<< 28))
            c = -(64'sd1 <<< 28);
        absc = (c < 0) ? -c : c;
        if (absc == 0)
        begin
            sat = 1'b1;
            aterm = 0;
        end
        else
        begin
            s = int_sqrt((64'd1 << 56) - absc * absc);
            aterm = (s << 8) / absc;
        end
        total = dterm + aterm;
        if (sat || total > 64'hFFFF_FFFF)
        begin
            total = 64'hFFFF_FFFF;
            sat = 1'b1;
        end
        res.metric_value = total[31:0];
        res.saturated = sat;
        return res;
    endfunction

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: presents beats from the pending queue, with random gaps between them.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                int next_gap;
                // The beat just went in; predict it against the current scale.
                owed_metrics = {owed_metrics, predict_metric(in_data, scale_shadow)};
                void'(pending_beats.pop_front());
                next_gap = gap_length();
                if (pending_beats.size() > 0 && next_gap == 0 && !drain_hold)
                begin
                    in_data <= pending_beats[0];
                    send_gap <= 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    send_gap <= next_gap;
                end
            end
            else if (!in_valid)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (pending_beats.size() > 0 && !drain_hold)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_beats[0];
                end
            end
        end
    end

    // Monitor: random stall on the result side, and the field by field check.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_metrics.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got value %h sat %b",
                             $time, out_data.metric_value, out_data.saturated);
                    errors++;
                end
                else
                begin
                    tld_pkg::out_item_t exp_m;
                    exp_m = owed_metrics.pop_front();
                    if (exp_m.metric_value !== out_data.metric_value)
                    begin
                        $display("%0t: metric_value expected %h actual %h",
                                 $time, exp_m.metric_value, out_data.metric_value);
                        errors++;
                    end
                    if (exp_m.saturated !== out_data.saturated)
                    begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, exp_m.saturated, out_data.saturated);
                        errors++;
                    end
                    metrics_seen++;
                    if (out_data.saturated)
                        sat_seen++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                stall_left <= gap_length();
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_triplet_line_distance_metric_top: FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] rand_dir_comp();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'sd16384;
        if (pick == 1)
            return -16'sd16384;
        if (pick == 2)
            return 16'($urandom());
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [23:0] rand_center();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return 24'($signed($urandom_range(0, 8192)) - 4096);
        if (pick == 5)
            return 24'h7FFFFF;
        if (pick == 6)
            return 24'h800000;
        return 24'($urandom());
    endfunction

    // A mostly unit-length direction: a random vector scaled to unit length, or random components.
    task automatic rand_unit_dir(output logic signed [15:0] x, output logic signed [15:0] y,
                                 output logic signed [15:0] z);
        real a, b, n;
        real vx, vy, vz;
        if ($urandom_range(0, 3) == 0)
        begin
            x = rand_dir_comp();
            y = rand_dir_comp();
            z = rand_dir_comp();
        end
        else
        begin
            vx = $itor($signed($urandom_range(0, 2000)) - 1000);
            vy = $itor($signed($urandom_range(0, 2000)) - 1000);
            vz = $itor($signed($urandom_range(0, 2000)) - 1000);
            n = $sqrt(vx * vx + vy * vy + vz * vz);
            if (n < 1.0)
            begin
                vx = 1.0;
                n = 1.0;
            end
            a = 16384.0 / n;
            b = 0.0;
            x = 16'($rtoi(vx * a + b));
            y = 16'($rtoi(vy * a));
            z = 16'($rtoi(vz * a));
        end
    endtask

    task automatic queue_random_beat();
        tld_pkg::in_item_t b;
        b.first_center_x = rand_center();
        b.first_center_y = rand_center();
        b.first_center_z = rand_center();
        b.second_center_x = rand_center();
        b.second_center_y = rand_center();
        b.second_center_z = rand_center();
        rand_unit_dir(b.first_dir_x, b.first_dir_y, b.first_dir_z);
        if ($urandom_range(0, 4) == 0)
        begin
            // Parallel or antiparallel second segment: angle term near zero.
            b.second_dir_x = b.first_dir_x;
            b.second_dir_y = b.first_dir_y;
            b.second_dir_z = b.first_dir_z;
            if ($urandom_range(0, 1))
            begin
                b.second_dir_x = -b.first_dir_x;
                b.second_dir_y = -b.first_dir_y;
                b.second_dir_z = -b.first_dir_z;
            end
        end
        else
            rand_unit_dir(b.second_dir_x, b.second_dir_y, b.second_dir_z);
        pending_beats = {pending_beats, b};
    endtask

    task automatic queue_beat(input int c1x, input int c1y, input int c1z,
                              input int d1x, input int d1y, input int d1z,
                              input int c2x, input int c2y, input int c2z,
                              input int d2x, input int d2y, input int d2z);
        tld_pkg::in_item_t b;
        b = {24'(c1x), 24'(c1y), 24'(c1z), 16'(d1x), 16'(d1y), 16'(d1z),
             24'(c2x), 24'(c2y), 24'(c2z), 16'(d2x), 16'(d2y), 16'(d2z)};
        pending_beats = {pending_beats, b};
    endtask

    // Waits until the pipeline is empty, then writes the scale register.
    task automatic set_scale(input logic [15:0] value);
        wait (pending_beats.size() == 0 && !in_valid && owed_metrics.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        scale_shadow = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int count);
        for (int i = 0; i < count; i++)
            queue_random_beat();
    endtask

    localparam logic [15:0] ONE = 16'sd16384;
    localparam logic [15:0] MONE = -16'sd16384;

    initial
    begin
        errors = 0;
        metrics_seen = 0;
        sat_seen = 0;
        cycle_count = 0;
        drain_hold = 1'b0;
        scale_shadow = tld_pkg::SCALE_RESET;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset scale: parallel, antiparallel, perpendicular,
        // center extremes, directions off unit length and past the range.
        queue_beat(0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE, 0, 0);
        queue_beat(0, 256, 0, ONE, 0, 0, 0, 0, 0, MONE, 0, 0);
        queue_beat(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, ONE, 0);
        queue_beat(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, ONE, 0, 0,
                   24'h800000, 24'h800000, 24'h800000, 0, 0, ONE);
        queue_beat(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, ONE, 0,
                   24'h800000, 24'h7FFFFF, 24'h800000, 0, ONE, 0);
        queue_beat(100, -200, 300, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                   -5, 7, 9, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_beat(100, -200, 300, 16'h8000, 16'h8000, 16'h8000,
                   5, 7, 9, 16'h7FFF, 16'h8000, 16'h7FFF);
        queue_beat(0, 0, 0, 11585, 11585, 0, 0, 0, 4096, 11585, -11585, 1);
        queue_beat(1, 2, 3, 0, 0, 0, 4, 5, 6, 0, 0, 0);
        queue_beat(24'hFFFFFF, 0, 1, 9459, 9459, 9459, 0, 24'hFFFFFF, 0, 9459, 9459, 9460);
        queue_beat(1000, 0, 0, ONE, 0, 0, -1000, 77, 0, 16383, 181, 0);
        queue_beat(0, 0, 0, 0, 0, MONE, 0, 0, 0, 0, 1, ONE);
        run_random_phase(8);

        // Scale extremes and one ordinary setting, with random traffic in each.
        set_scale(16'd1);
        run_random_phase(300);
        set_scale(16'hFFFF);
        run_random_phase(300);
        set_scale(16'd0);
        run_random_phase(60);
        set_scale(16'd256);
        run_random_phase(300);

        // Let the pipeline drain completely once, then resume sending.
        wait (pending_beats.size() == 0 && !in_valid);
        drain_hold = 1'b1;
        run_random_phase(200);
        wait (owed_metrics.size() == 0);
        drain_hold = 1'b0;

        set_scale(16'd37);
        run_random_phase(300);
        set_scale(16'($urandom()));
        run_random_phase(400);

        wait (pending_beats.size() == 0 && !in_valid && owed_metrics.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Checked %0d metric beats (%0d saturated) over seven scale settings,",
                 metrics_seen, sat_seen);
        $display("including zero, one and full-range scale, with random stalls on both sides.");
        if (errors == 0 && owed_metrics.size() == 0)
            $display("tb_triplet_line_distance_metric_top: PASS");
        else
            $display("tb_triplet_line_distance_metric_top: FAIL");
        $finish;
    end

endmodule
